/* hw/rtl/aeg_pkg.sv */
// shared constants, register, segment, op and state codes, and the command/status structs
// for the envelope gain stage; no dependencies
`timescale 1ns / 1ps

package aeg_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int LENGTH_WIDTH    = 18;
  localparam int LEVEL_WIDTH     = 16;
  localparam int POS_WIDTH       = LENGTH_WIDTH + 2;
  localparam int GAIN_FRAC       = 15;
  localparam int SEG_WIDTH       = 3;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = (LENGTH_WIDTH > LEVEL_WIDTH) ? LENGTH_WIDTH : LEVEL_WIDTH;
  localparam int MCAND_WIDTH     = (LENGTH_WIDTH > SAMPLE_WIDTH) ? LENGTH_WIDTH
                                                                 : SAMPLE_WIDTH + 1;
  localparam int PROD_WIDTH      = MCAND_WIDTH + LEVEL_WIDTH;
  localparam int STEP_CNT_WIDTH  = $clog2(LEVEL_WIDTH);

  localparam logic [LEVEL_WIDTH-1:0] LEVEL_ONE = LEVEL_WIDTH'(64'd1 << GAIN_FRAC);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_ATTACK_LEN    = 3'd0,
    REG_ATTACK_LEVEL  = 3'd1,
    REG_DECAY_LEN     = 3'd2,
    REG_SUSTAIN_LEVEL = 3'd3,
    REG_SUSTAIN_LEN   = 3'd4,
    REG_RELEASE_LEN   = 3'd5
  } cfg_reg_e;

  typedef enum logic [SEG_WIDTH-1:0] {
    SEG_ATTACK  = 3'd0,
    SEG_DECAY   = 3'd1,
    SEG_SUSTAIN = 3'd2,
    SEG_RELEASE = 3'd3,
    SEG_SILENCE = 3'd4
  } seg_e;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUMD,
    ST_SUMS,
    ST_SUMR,
    ST_SEL,
    ST_MUL1,
    ST_DIV,
    ST_GAIN,
    ST_MUL2,
    ST_WB
  } state_e;

  // divide runs on whatever the previous multiply left in hi/lo
  typedef struct packed {
    logic                   start;
    op_e                    op;
    logic [MCAND_WIDTH-1:0] opnd;
    logic [LEVEL_WIDTH-1:0] mplier;
  } cmd_t;

  typedef struct packed {
    logic                   busy;
    logic [MCAND_WIDTH-1:0] hi;
    logic [LEVEL_WIDTH-1:0] lo;
  } status_t;

endpackage

/* hw/rtl/adsr_envelope_gain.sv */
// top level of the envelope gain stage: registers, position, sequencer, output
// depends on aeg_pkg and aeg_serial_unit
`timescale 1ns / 1ps

// Usage
// cfg channel: index 0..5 selects attack_len, attack_level, decay_len, sustain_level,
//   sustain_len, release_len; cfg_ready_o is always high; write only while idle.
// in channel: one item is a sample plus a restart flag; in_ready_o is high while
//   the sequencer is idle.
// out channel: one item per input item: scaled sample, gain, segment code.
// Sequence: from accept to the output register an item in a ramp segment
//   (attack, decay, release) passes three bound sums, the select, a 16-step
//   multiply for the ramp product and a 16-step divide by the segment length on
//   the shared serial unit, the gain step, a 16-step multiply of the sample by
//   the gain, and the write-back; sustain and silence skip the ramp multiply and
//   the divide.
// Overlap: the next item is accepted the cycle after the result is loaded, while
//   that result still sits in the output register.
// Stall: while the output register holds an item and out_ready_i is low, the
//   finished result waits in the sequencer until the output register frees.
// Reset: lengths 0, levels 1.0, position 0, output empty.
module adsr_envelope_gain (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [aeg_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index_i,
  input  logic [aeg_pkg::CFG_DATA_WIDTH-1:0]      cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [aeg_pkg::SAMPLE_WIDTH-1:0] sample_in_i,
  input  logic                                    restart_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [aeg_pkg::SAMPLE_WIDTH-1:0] sample_out_o,
  output logic [aeg_pkg::LEVEL_WIDTH-1:0]         env_gain_o,
  output logic [aeg_pkg::SEG_WIDTH-1:0]           segment_o
);
  import aeg_pkg::*;

  localparam int SH_WIDTH = PROD_WIDTH + 1 - GAIN_FRAC;
  localparam logic [SH_WIDTH-1:0] SMAX_SH =
    SH_WIDTH'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
  localparam logic [SH_WIDTH-1:0] SMIN_MAG_SH = SH_WIDTH'(64'd1 << (SAMPLE_WIDTH - 1));
  localparam logic [PROD_WIDTH:0] ROUND_NEG = (PROD_WIDTH+1)'((64'd1 << GAIN_FRAC) - 64'd1);

  state_e state_q, state_d;

  logic [LENGTH_WIDTH-1:0] attack_len_q, decay_len_q, sustain_len_q, release_len_q;
  logic [LEVEL_WIDTH-1:0]  attack_level_q, sustain_level_q;

  logic [POS_WIDTH-1:0]    pos_q;
  logic [POS_WIDTH-1:0]    a_end, d_end_q, s_end_q, r_end_q;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;

  seg_e                    seg_q, seg_d;
  logic                    ramp_q, ramp_d;
  logic                    neg_q, neg_d;
  logic [LEVEL_WIDTH-1:0]  start_q, start_d;
  logic [LEVEL_WIDTH-1:0]  mag_d;
  logic [LENGTH_WIDTH-1:0] len_q, len_d;
  logic [POS_WIDTH-1:0]    base_d;
  logic [POS_WIDTH-1:0]    k_full;
  logic [LEVEL_WIDTH-1:0]  gain_q, gain_d;

  logic [SAMPLE_WIDTH:0]   s_ext, smag;
  logic [PROD_WIDTH-1:0]   prod;
  logic [PROD_WIDTH:0]     rounded;
  logic [SH_WIDTH-1:0]     shifted;
  logic signed [SAMPLE_WIDTH-1:0] res_d;

  logic                    out_free;
  logic                    out_load;

  cmd_t    cmd;
  status_t status;

  aeg_serial_unit u_serial (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status)
  );

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_len_q    <= '0;
      attack_level_q  <= LEVEL_ONE;
      decay_len_q     <= '0;
      sustain_level_q <= LEVEL_ONE;
      sustain_len_q   <= '0;
      release_len_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ATTACK_LEN:    attack_len_q    <= cfg_data_i[LENGTH_WIDTH-1:0];
        REG_ATTACK_LEVEL:  attack_level_q  <= cfg_data_i[LEVEL_WIDTH-1:0];
        REG_DECAY_LEN:     decay_len_q     <= cfg_data_i[LENGTH_WIDTH-1:0];
        REG_SUSTAIN_LEVEL: sustain_level_q <= cfg_data_i[LEVEL_WIDTH-1:0];
        REG_SUSTAIN_LEN:   sustain_len_q   <= cfg_data_i[LENGTH_WIDTH-1:0];
        REG_RELEASE_LEN:   release_len_q   <= cfg_data_i[LENGTH_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // segment select
  assign a_end = POS_WIDTH'(attack_len_q);

  always_comb begin
    seg_d   = SEG_SILENCE;
    ramp_d  = 1'b0;
    neg_d   = 1'b0;
    start_d = '0;
    mag_d   = '0;
    len_d   = release_len_q;
    base_d  = s_end_q;
    if (pos_q < a_end) begin
      seg_d   = SEG_ATTACK;
      ramp_d  = 1'b1;
      mag_d   = attack_level_q;
      len_d   = attack_len_q;
      base_d  = '0;
    end else if (pos_q < d_end_q) begin
      seg_d   = SEG_DECAY;
      ramp_d  = 1'b1;
      start_d = attack_level_q;
      len_d   = decay_len_q;
      base_d  = a_end;
      if (sustain_level_q >= attack_level_q) begin
        mag_d = sustain_level_q - attack_level_q;
      end else begin
        neg_d = 1'b1;
        mag_d = attack_level_q - sustain_level_q;
      end
    end else if (pos_q < s_end_q) begin
      seg_d   = SEG_SUSTAIN;
      start_d = sustain_level_q;
    end else if (pos_q < r_end_q) begin
      seg_d   = SEG_RELEASE;
      ramp_d  = 1'b1;
      neg_d   = 1'b1;
      start_d = sustain_level_q;
      mag_d   = sustain_level_q;
    end
  end

  assign k_full = pos_q - base_d;

  // gain: start level, plus or minus the quotient in a ramp segment
  assign gain_d = !ramp_q ? start_q
                : (neg_q ? start_q - status.lo : start_q + status.lo);

  // sample magnitude and final scaling
  assign s_ext   = {sample_q[SAMPLE_WIDTH-1], sample_q};
  assign smag    = sample_q[SAMPLE_WIDTH-1] ? (~s_ext + 1'b1) : s_ext;
  assign prod    = {status.hi, status.lo};
  assign rounded = {1'b0, prod} + (sample_q[SAMPLE_WIDTH-1] ? ROUND_NEG : '0);
  assign shifted = rounded[PROD_WIDTH:GAIN_FRAC];

  always_comb begin
    if (!sample_q[SAMPLE_WIDTH-1]) begin
      res_d = (shifted > SMAX_SH) ? {1'b0, {(SAMPLE_WIDTH-1){1'b1}}}
                                  : shifted[SAMPLE_WIDTH-1:0];
    end else begin
      res_d = (shifted > SMIN_MAG_SH) ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                      : ~shifted[SAMPLE_WIDTH-1:0] + 1'b1;
    end
  end

  assign out_free = !out_valid_o || out_ready_i;
  assign out_load = (state_q == ST_WB) && out_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_SUMD;
      ST_SUMD: state_d = ST_SUMS;
      ST_SUMS: state_d = ST_SUMR;
      ST_SUMR: state_d = ST_SEL;
      ST_SEL:  state_d = ramp_d ? ST_MUL1 : ST_GAIN;
      ST_MUL1: if (!status.busy) state_d = ST_DIV;
      ST_DIV:  if (!status.busy) state_d = ST_GAIN;
      ST_GAIN: state_d = ST_MUL2;
      ST_MUL2: if (!status.busy) state_d = ST_WB;
      ST_WB:   if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd.start  = 1'b0;
    cmd.op     = OP_MUL;
    cmd.opnd   = MCAND_WIDTH'(k_full[LENGTH_WIDTH-1:0]);
    cmd.mplier = mag_d;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_SEL:  cmd.start = ramp_d;
      ST_MUL1: begin
        cmd.start = !status.busy;
        cmd.op    = OP_DIV;
        cmd.opnd  = MCAND_WIDTH'(len_q);
      end
      ST_GAIN: begin
        cmd.start  = 1'b1;
        cmd.opnd   = MCAND_WIDTH'(smag);
        cmd.mplier = gain_d;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_valid_i && in_ready_o && restart_i) begin
        pos_q <= '0;
      end else if (state_q == ST_SEL && pos_q < r_end_q) begin
        pos_q <= pos_q + 1'b1;
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sample_q <= sample_in_i;
    end
    if (state_q == ST_SUMD) begin
      d_end_q <= a_end + POS_WIDTH'(decay_len_q);
    end
    if (state_q == ST_SUMS) begin
      s_end_q <= d_end_q + POS_WIDTH'(sustain_len_q);
    end
    if (state_q == ST_SUMR) begin
      r_end_q <= s_end_q + POS_WIDTH'(release_len_q);
    end
    if (state_q == ST_SEL) begin
      seg_q   <= seg_d;
      ramp_q  <= ramp_d;
      neg_q   <= neg_d;
      start_q <= start_d;
      len_q   <= len_d;
    end
    if (state_q == ST_GAIN) begin
      gain_q <= gain_d;
    end
    if (out_load) begin
      sample_out_o <= res_d;
      env_gain_o   <= gain_q;
      segment_o    <= seg_q;
    end
  end

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item accepted while busy");
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEL && pos_q < r_end_q) |=> (pos_q == POS_WIDTH'($past(pos_q) + 1'b1)))
    else $error("position did not advance");
  a_silent_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && segment_o == SEG_SILENCE) |-> (env_gain_o == '0))
    else $error("nonzero gain in silence");
`endif

endmodule

/* hw/rtl/aeg_serial_unit.sv */
// bit-serial shift-add multiplier and restoring divider sharing one hi/lo pair
// depends on aeg_pkg
`timescale 1ns / 1ps

module aeg_serial_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  aeg_pkg::cmd_t  cmd_i,
  output aeg_pkg::status_t status_o
);
  import aeg_pkg::*;

  logic                      busy_q, busy_d;
  op_e                       op_q, op_d;
  logic [STEP_CNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [MCAND_WIDTH-1:0]    opnd_q, opnd_d;
  logic [MCAND_WIDTH-1:0]    hi_q, hi_d;
  logic [LEVEL_WIDTH-1:0]    lo_q, lo_d;

  logic [MCAND_WIDTH:0]      add_sum;
  logic [MCAND_WIDTH:0]      rem_ext;
  logic [MCAND_WIDTH:0]      sub_diff;
  logic                      rem_ge;

  assign add_sum  = {1'b0, hi_q} + {1'b0, (lo_q[0] ? opnd_q : '0)};
  assign rem_ext  = {hi_q, lo_q[LEVEL_WIDTH-1]};
  assign rem_ge   = rem_ext >= {1'b0, opnd_q};
  assign sub_diff = rem_ext - {1'b0, opnd_q};

  always_comb begin
    busy_d = busy_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    opnd_d = opnd_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    if (busy_q) begin
      if (op_q == OP_MUL) begin
        hi_d = add_sum[MCAND_WIDTH:1];
        lo_d = {add_sum[0], lo_q[LEVEL_WIDTH-1:1]};
      end else begin
        hi_d = rem_ge ? sub_diff[MCAND_WIDTH-1:0] : rem_ext[MCAND_WIDTH-1:0];
        lo_d = {lo_q[LEVEL_WIDTH-2:0], rem_ge};
      end
      if (cnt_q == STEP_CNT_WIDTH'(LEVEL_WIDTH - 1)) begin
        busy_d = 1'b0;
        cnt_d  = '0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end else if (cmd_i.start) begin
      busy_d = 1'b1;
      op_d   = cmd_i.op;
      opnd_d = cmd_i.opnd;
      if (cmd_i.op == OP_MUL) begin
        hi_d = '0;
        lo_d = cmd_i.mplier;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      op_q   <= OP_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opnd_q <= opnd_d;
    hi_q   <= hi_d;
    lo_q   <= lo_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.hi   = hi_q;
  assign status_o.lo   = lo_q;

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> !busy_q)
    else $error("serial unit started while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |=> busy_q)
    else $error("serial unit did not start");
  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.start && cmd_i.op == OP_DIV) |-> (hi_q < cmd_i.opnd))
    else $error("quotient would overflow");
`endif

endmodule
